FILE: hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the q24.8 fixed-point alu
// commands, status codes, and the word structs, including the one for the divider cell step
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned FracBits  = 8;
  // divider quotient bits, one per cell
  localparam int unsigned QuotBits  = WordWidth + FracBits;
  localparam int unsigned NumCells  = QuotBits;

  typedef enum logic [4:0] {
    CmdAdd       = 5'd0,
    CmdSub       = 5'd1,
    CmdMul       = 5'd2,
    CmdDiv       = 5'd3,
    CmdGt        = 5'd4,
    CmdGe        = 5'd5,
    CmdLt        = 5'd6,
    CmdLe        = 5'd7,
    CmdEq        = 5'd8,
    CmdNe        = 5'd9,
    CmdMin       = 5'd10,
    CmdMax       = 5'd11,
    CmdInc       = 5'd12,
    CmdDec       = 5'd13,
    CmdFromInt   = 5'd14,
    CmdToInt     = 5'd15,
    CmdFromFloat = 5'd16,
    CmdToFloat   = 5'd17
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusDivZero = 2'd1,
    StatusFloat  = 2'd2
  } status_e;

  typedef struct packed {
    logic [4:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [31:0]        float_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [31:0]        float_out;
    logic [1:0]         status;
  } out_word_t;

  // word carried along the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 is_div;
    logic                 neg;
    logic [QuotBits-1:0]  rem;   // partial remainder (magnitudes)
    logic [QuotBits-1:0]  dvd;   // dividend bits still to shift in, then quotient
    logic [WordWidth-1:0] dvs;   // divisor magnitude
    out_word_t            res;   // precomputed result for other commands
  } cell_word_t;

endpackage

FILE: hdl/fixed_point_q24_8_alu_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit: q24.8 fixed-point alu
// front stage, a chain of division cells, and an output register
// ----------------------------------------------------------------------------
// channel  dir  handshake          word
// in       in   in_valid/in_ready  fpa_pkg::in_word_t
// out      out  out_valid/out_ready fpa_pkg::out_word_t
//
// one word per cycle while the output is not stalled; every command takes the same path:
// front stage, 40 division cells and the output register.
// the whole chain advances together whenever the output slot is empty or
// being taken, so a stalled output holds every word in place.
// reset empties the chain.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fpa_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fpa_pkg::out_word_t out_word_o
);

  localparam int unsigned N = fpa_pkg::NumCells;
  localparam int unsigned W = fpa_pkg::WordWidth;

  fpa_pkg::cell_word_t chain [N+1];
  logic                adv;
  logic                out_valid_q;
  fpa_pkg::out_word_t  out_word_q, out_word_d;
  logic [W-1:0]        quot;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  fpa_front u_front (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_valid_i),
    .word_i(in_word_i), .word_o(chain[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    fpa_cell u_cell (
      .clk_i, .rst_ni, .en_i(adv), .word_i(chain[i]), .word_o(chain[i+1])
    );
  end

  always_comb begin
    out_word_d = chain[N].res;
    quot = chain[N].dvd[W-1:0];
    if (chain[N].is_div) begin
      out_word_d.result_value = 32'($signed(chain[N].neg ? W'(-quot) : quot));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain[N].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: entry stage
// computes every non-divide command in one registered step and loads the
// divider operands into the first chain word
// ----------------------------------------------------------------------------
module fpa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  fpa_pkg::in_word_t   word_i,
  output fpa_pkg::cell_word_t word_o
);

  localparam int unsigned W = fpa_pkg::WordWidth;
  localparam int unsigned F = fpa_pkg::FracBits;

  fpa_pkg::cell_word_t word_d, word_q;

  logic signed [W-1:0]   a, b;
  logic signed [2*W-1:0] prod;
  logic                  lt, eq;
  logic [W-1:0]          mag_a, mag_b;
  logic [31:0]           fo;
  logic [31:0]           ff_res;
  logic [1:0]            ff_st;

  // float to fixed, round half away from zero
  logic                  fsign;
  logic [7:0]            fex;
  logic [23:0]           fman;
  logic signed [10:0]    fe;
  logic [63:0]           fmag;
  logic [W:0]            flim;
  logic                  fover;
  logic [5:0]            fsh;

  // fixed to float, round to nearest even
  logic [W-1:0]          tmag;
  logic [5:0]            tp;
  logic [W-1:0]          tm, trem, thalf;
  logic [5:0]            tsh;
  logic [24:0]           tmr;
  logic [7:0]            texp;

  always_comb begin
    a = word_i.operand_a[W-1:0];
    b = word_i.operand_b[W-1:0];
    prod = a * b;
    lt = a < b;
    eq = a == b;
    mag_a = a[W-1] ? W'(-a) : W'(a);
    mag_b = b[W-1] ? W'(-b) : W'(b);

    fsign = word_i.float_in[31];
    fex   = word_i.float_in[30:23];
    fman  = {(fex != 8'd0), word_i.float_in[22:0]};
    fe    = (fex == 8'd0) ? -11'sd149 : $signed({3'b000, fex}) - 11'sd150;
    fe    = fe + 11'(F);
    flim  = fsign ? (W+1)'(1) << (W-1) : ((W+1)'(1) << (W-1)) - (W+1)'(1);
    fover = 1'b0;
    fmag  = '0;
    fsh   = '0;
    ff_st = fpa_pkg::StatusOk;
    if (fex == 8'hff) begin
      fover = (fman[22:0] == 23'd0);
    end else if (fe >= 0) begin
      if (fe >= 11'sd40) fover = (fman != 24'd0);
      else fmag = {40'd0, fman} << fe[5:0];
    end else if (fe >= -11'sd25) begin
      fsh  = 6'(-fe);
      fmag = ({40'd0, fman} + (64'd1 << (fsh - 6'd1))) >> fsh;
    end
    if (fmag > 64'(flim)) fover = 1'b1;
    if (fex == 8'hff && fman[22:0] != 23'd0) begin
      ff_res = '0;
      ff_st  = fpa_pkg::StatusFloat;
    end else begin
      if (fover) begin
        fmag  = 64'(flim);
        ff_st = fpa_pkg::StatusFloat;
      end
      ff_res = 32'($signed((fsign ? W'(-fmag[W-1:0]) : fmag[W-1:0])));
    end

    tmag = mag_a;
    tp = '0;
    for (int i = 0; i < W; i++) if (tmag[i]) tp = 6'(i);
    tsh = '0;
    trem = '0;
    thalf = '0;
    tm = '0;
    texp = 8'(tp) + 8'd127 - 8'(F);
    if (tp <= 6'd23) begin
      tm = tmag << (6'd23 - tp);
      tmr = tm[24:0];
    end else begin
      tsh   = tp - 6'd23;
      trem  = tmag & ((W'(1) << tsh) - W'(1));
      thalf = W'(1) << (tsh - 6'd1);
      tm    = tmag >> tsh;
      tmr   = tm[24:0];
      if (trem > thalf || (trem == thalf && tm[0])) tmr = tmr + 25'd1;
      if (tmr[24]) begin
        tmr  = tmr >> 1;
        texp = texp + 8'd1;
      end
    end
    fo = (tmag == '0) ? 32'd0 : {a[W-1], texp, tmr[22:0]};

    word_d = '0;
    word_d.valid = valid_i;
    word_d.res.status = fpa_pkg::StatusOk;
    unique case (word_i.command)
      fpa_pkg::CmdAdd: word_d.res.result_value = 32'(a + b);
      fpa_pkg::CmdSub: word_d.res.result_value = 32'(a - b);
      fpa_pkg::CmdMul: word_d.res.result_value = 32'($signed(W'(prod >>> F)));
      fpa_pkg::CmdDiv: begin
        if (b == '0) begin
          word_d.res.status = fpa_pkg::StatusDivZero;
        end else begin
          word_d.is_div = 1'b1;
          word_d.neg    = a[W-1] ^ b[W-1];
          word_d.dvd    = {mag_a, F'(0)};
          word_d.dvs    = mag_b;
        end
      end
      fpa_pkg::CmdGt: word_d.res.compare_true = !lt && !eq;
      fpa_pkg::CmdGe: word_d.res.compare_true = !lt;
      fpa_pkg::CmdLt: word_d.res.compare_true = lt;
      fpa_pkg::CmdLe: word_d.res.compare_true = lt || eq;
      fpa_pkg::CmdEq: word_d.res.compare_true = eq;
      fpa_pkg::CmdNe: word_d.res.compare_true = !eq;
      fpa_pkg::CmdMin: word_d.res.result_value = 32'((lt || eq) ? a : b);
      fpa_pkg::CmdMax: word_d.res.result_value = 32'(!lt ? a : b);
      fpa_pkg::CmdInc: word_d.res.result_value = 32'($signed(W'(a + 1)));
      fpa_pkg::CmdDec: word_d.res.result_value = 32'($signed(W'(a - 1)));
      fpa_pkg::CmdFromInt: word_d.res.result_value = 32'($signed(W'(a <<< F)));
      fpa_pkg::CmdToInt: word_d.res.result_value = 32'($signed(W'(a >>> F)));
      fpa_pkg::CmdFromFloat: begin
        word_d.res.result_value = ff_res;
        word_d.res.status       = ff_st;
      end
      fpa_pkg::CmdToFloat: word_d.res.float_out = fo;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

FILE: hdl/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell: one restoring-division step
// shifts one dividend bit into the remainder and produces one quotient bit
// ----------------------------------------------------------------------------
module fpa_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  fpa_pkg::cell_word_t word_i,
  output fpa_pkg::cell_word_t word_o
);

  localparam int unsigned Q = fpa_pkg::QuotBits;

  fpa_pkg::cell_word_t word_d, word_q;
  logic [Q:0]          trial;

  always_comb begin
    word_d = word_i;
    trial  = {word_i.rem, word_i.dvd[Q-1]} - (Q+1)'(word_i.dvs);
    if (word_i.is_div) begin
      if (!trial[Q]) begin
        word_d.rem = trial[Q-1:0];
        word_d.dvd = {word_i.dvd[Q-2:0], 1'b1};
      end else begin
        word_d.rem = {word_i.rem[Q-2:0], word_i.dvd[Q-1]};
        word_d.dvd = {word_i.dvd[Q-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

FILE: tb/fixed_point_q24_8_alu_unit_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit_tb: self-checking bench for the q24.8 alu
// drives a directed table and then random words through the valid/ready
// channels, predicts each result or takes it from the table, and compares it field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fixed_point_q24_8_alu_unit_tb;

  localparam logic [4:0] CmdUnusedTop = 5'd31;
  localparam int         HoldLen      = 400;
  localparam int         StallLimit   = 3000;
  localparam int         DrainCycles  = 60;
  localparam int         PhaseItems   = 450;

  typedef struct {
    fpa_pkg::in_word_t  w;
    bit                 typed;
    fpa_pkg::out_word_t res;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  fpa_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  fpa_pkg::out_word_t out_word_o;

  fpa_pkg::out_word_t expected_q[$];
  stim_row_t          stim_table[$];
  int                 fail_count = 0;
  int                 idle_send = 0;
  int                 idle_recv = 0;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;
  int                 stall_cycles = 0;

  fixed_point_q24_8_alu_unit DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic fpa_pkg::out_word_t mk_out(logic [31:0] r, logic c, logic [31:0] f,
                                                fpa_pkg::status_e s);
    fpa_pkg::out_word_t o;
    o.result_value = r;
    o.compare_true = c;
    o.float_out    = f;
    o.status       = s;
    return o;
  endfunction

  function automatic logic [31:0] float_to_q24_8(logic [31:0] bits,
                                                 output fpa_pkg::status_e st);
    logic        sgn;
    logic [7:0]  ex;
    logic [63:0] man, mag, lim, sh;
    int          e;
    bit          over;
    sgn  = bits[31];
    ex   = bits[30:23];
    man  = {41'd0, bits[22:0]};
    lim  = sgn ? 64'h8000_0000 : 64'h7fff_ffff;
    over = 1'b0;
    mag  = '0;
    st   = fpa_pkg::StatusOk;
    if (ex == 8'hff) begin
      if (man != 0) begin
        st = fpa_pkg::StatusFloat;
        return '0;
      end
      over = 1'b1;
    end else begin
      if (ex == 0) e = -149;
      else begin
        man[23] = 1'b1;
        e = int'(ex) - 150;
      end
      e += fpa_pkg::FracBits;
      if (e >= 0) begin
        if (e >= 40) over = (man != 0);
        else mag = man << e;
      end else begin
        sh = -e;
        // round half away from zero on the magnitude
        if (sh <= 25) mag = (man + (64'd1 << (sh - 1))) >> sh;
      end
      if (!over && mag > lim) over = 1'b1;
    end
    if (over) begin
      st  = fpa_pkg::StatusFloat;
      mag = lim;
    end
    return sgn ? 32'(-mag) : 32'(mag);
  endfunction

  function automatic logic [31:0] q24_8_to_float(logic signed [31:0] v);
    logic [63:0] mag, m, rem, half;
    int          p, sh;
    if (v == 0) return '0;
    mag = v < 0 ? -64'(v) : 64'(v);
    p = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) p = i;
    if (p <= 23) m = mag << (23 - p);
    else begin
      sh   = p - 23;
      rem  = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      m    = mag >> sh;
      // nearest even
      if (rem > half || (rem == half && m[0])) m++;
      if (m[24]) begin
        m = m >> 1;
        p++;
      end
    end
    return {v[31], 8'(p - fpa_pkg::FracBits + 127), m[22:0]};
  endfunction

  function automatic fpa_pkg::out_word_t alu_predict(fpa_pkg::in_word_t w);
    logic signed [31:0] a, b;
    longint             prod, quot;
    fpa_pkg::status_e   fst;
    fpa_pkg::out_word_t o;
    a = w.operand_a;
    b = w.operand_b;
    o = mk_out('0, 1'b0, '0, fpa_pkg::StatusOk);
    case (w.command)
      fpa_pkg::CmdAdd:   o.result_value = a + b;
      fpa_pkg::CmdSub:   o.result_value = a - b;
      fpa_pkg::CmdMul: begin
        prod = longint'(a) * longint'(b);
        o.result_value = 32'(prod >>> fpa_pkg::FracBits);
      end
      fpa_pkg::CmdDiv: begin
        if (b == 0) o.status = fpa_pkg::StatusDivZero;
        else begin
          quot = (longint'(a) * 256) / longint'(b);
          o.result_value = 32'(quot);
        end
      end
      fpa_pkg::CmdGt:    o.compare_true = a > b;
      fpa_pkg::CmdGe:    o.compare_true = a >= b;
      fpa_pkg::CmdLt:    o.compare_true = a < b;
      fpa_pkg::CmdLe:    o.compare_true = a <= b;
      fpa_pkg::CmdEq:    o.compare_true = a == b;
      fpa_pkg::CmdNe:    o.compare_true = a != b;
      fpa_pkg::CmdMin:   o.result_value = (a <= b) ? a : b;
      fpa_pkg::CmdMax:   o.result_value = (a >= b) ? a : b;
      fpa_pkg::CmdInc:   o.result_value = a + 1;
      fpa_pkg::CmdDec:   o.result_value = a - 1;
      fpa_pkg::CmdFromInt: o.result_value = a << fpa_pkg::FracBits;
      fpa_pkg::CmdToInt: o.result_value = a >>> fpa_pkg::FracBits;
      fpa_pkg::CmdFromFloat: begin
        o.result_value = float_to_q24_8(w.float_in, fst);
        o.status = fst;
      end
      fpa_pkg::CmdToFloat: o.float_out = q24_8_to_float(a);
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 6))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 4095)) - 32'd2048;
      3: return $urandom >> $urandom_range(0, 31);
      4: return -($urandom >> $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return {1'($urandom), 8'hff, ($urandom_range(0, 1) ? 23'd0 : 23'($urandom))};
      2: return {1'($urandom), 8'd0, 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(100, 165)), 23'($urandom)};
    endcase
  endfunction

  function automatic fpa_pkg::in_word_t rand_word();
    fpa_pkg::in_word_t w;
    w.command   = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                               : 5'($urandom_range(0, 17));
    w.operand_a = rand_operand();
    w.operand_b = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_operand();
    w.float_in  = rand_float();
    return w;
  endfunction

  task automatic add_row(fpa_pkg::cmd_e c, logic [31:0] a, logic [31:0] b, logic [31:0] f,
                         bit typed = 1'b0, fpa_pkg::out_word_t res = '0);
    stim_row_t r;
    r.w     = '{command: c, operand_a: a, operand_b: b, float_in: f};
    r.typed = typed;
    r.res   = res;
    stim_table.push_back(r);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(fpa_pkg::in_word_t w, bit typed, fpa_pkg::out_word_t res);
    while ($urandom_range(0, 99) < idle_send) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(typed ? res : alu_predict(w));
    @(negedge clk_i);
  endtask

  // receiver side
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldLen;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= idle_recv);
    end
  end

  always @(posedge clk_i) begin
    fpa_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_word_o);
        fail_count++;
      end else begin
        exp_w = expected_q.pop_front();
        if (out_word_o.result_value !== exp_w.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   exp_w.result_value, out_word_o.result_value);
          fail_count++;
        end
        if (out_word_o.compare_true !== exp_w.compare_true) begin
          $display("%0t: compare_true expected %b actual %b", $time,
                   exp_w.compare_true, out_word_o.compare_true);
          fail_count++;
        end
        if (out_word_o.float_out !== exp_w.float_out) begin
          $display("%0t: float_out expected %h actual %h", $time,
                   exp_w.float_out, out_word_o.float_out);
          fail_count++;
        end
        if (out_word_o.status !== exp_w.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_w.status, out_word_o.status);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
    else if (rst_ni) stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int sets_send[3];
    int sets_recv[3];
    sets_send = '{31, 54, 0};
    sets_recv = '{54, 31, 0};

    add_row(fpa_pkg::CmdAdd, 32'h7fff_ffff, 32'd1, '0, 1'b1,
            mk_out(32'h8000_0000, 1'b0, '0, fpa_pkg::StatusOk));
    add_row(fpa_pkg::CmdSub, 32'h8000_0000, 32'd1, '0, 1'b1,
            mk_out(32'h7fff_ffff, 1'b0, '0, fpa_pkg::StatusOk));
    add_row(fpa_pkg::CmdMul, 32'h7fff_ffff, 32'h8000_0000, '0);
    add_row(fpa_pkg::CmdMul, 32'hffff_ff80, 32'h0000_0180, '0);
    add_row(fpa_pkg::CmdDiv, 32'h8000_0000, 32'hffff_ffff, '0);
    add_row(fpa_pkg::CmdDiv, 32'd1234, 32'd0, '0, 1'b1,
            mk_out('0, 1'b0, '0, fpa_pkg::StatusDivZero));
    add_row(fpa_pkg::CmdDiv, 32'hffff_fd00, 32'd7, '0);
    add_row(fpa_pkg::CmdGt, 32'h8000_0000, 32'h7fff_ffff, '0);
    add_row(fpa_pkg::CmdGe, 32'd5, 32'd5, '0);
    add_row(fpa_pkg::CmdLt, 32'h8000_0000, 32'h7fff_ffff, '0);
    add_row(fpa_pkg::CmdLe, 32'h7fff_ffff, 32'h8000_0000, '0);
    add_row(fpa_pkg::CmdEq, 32'hffff_ffff, 32'hffff_ffff, '0);
    add_row(fpa_pkg::CmdNe, 32'd0, 32'hffff_ffff, '0);
    add_row(fpa_pkg::CmdMin, 32'h8000_0000, 32'h7fff_ffff, '0);
    add_row(fpa_pkg::CmdMax, 32'h8000_0000, 32'h7fff_ffff, '0);
    add_row(fpa_pkg::CmdInc, 32'h7fff_ffff, '0, '0, 1'b1,
            mk_out(32'h8000_0000, 1'b0, '0, fpa_pkg::StatusOk));
    add_row(fpa_pkg::CmdDec, 32'h8000_0000, '0, '0, 1'b1,
            mk_out(32'h7fff_ffff, 1'b0, '0, fpa_pkg::StatusOk));
    add_row(fpa_pkg::CmdFromInt, 32'hff80_0001, '0, '0);
    add_row(fpa_pkg::CmdToInt, 32'hffff_ffff, '0, '0, 1'b1,
            mk_out(32'hffff_ffff, 1'b0, '0, fpa_pkg::StatusOk));
    // nan, both infinities (overflow), negative zero, a half-way tiny value
    add_row(fpa_pkg::CmdFromFloat, '0, '0, 32'h7fc0_0000, 1'b1,
            mk_out('0, 1'b0, '0, fpa_pkg::StatusFloat));
    add_row(fpa_pkg::CmdFromFloat, '0, '0, 32'h7f80_0000, 1'b1,
            mk_out(32'h7fff_ffff, 1'b0, '0, fpa_pkg::StatusFloat));
    add_row(fpa_pkg::CmdFromFloat, '0, '0, 32'hff80_0000, 1'b1,
            mk_out(32'h8000_0000, 1'b0, '0, fpa_pkg::StatusFloat));
    add_row(fpa_pkg::CmdFromFloat, '0, '0, 32'h8000_0000, 1'b1,
            mk_out('0, 1'b0, '0, fpa_pkg::StatusOk));
    add_row(fpa_pkg::CmdFromFloat, '0, '0, 32'hbb00_0000);
    add_row(fpa_pkg::CmdToFloat, 32'h8000_0000, '0, '0);
    add_row(fpa_pkg::CmdToFloat, 32'h00ff_ffff, '0, '0);
    add_row(fpa_pkg::cmd_e'(CmdUnusedTop), 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            1'b1, mk_out('0, 1'b0, '0, fpa_pkg::StatusOk));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_table[i]) send_word(stim_table[i].w, stim_table[i].typed, stim_table[i].res);

    for (int ph = 0; ph < 3; ph++) begin
      idle_send = sets_send[ph];
      idle_recv = sets_recv[ph];
      for (int n = 0; n < PhaseItems; n++) begin
        // long receiver hold while words keep coming, fills the chain
        if (ph == 0 && n == 100) hold_req = 1'b1;
        send_word(rand_word(), 1'b0, '0);
      end
      // sender pauses until the chain has drained
      in_valid_i <= 1'b0;
      wait (expected_q.size() == 0);
      @(negedge clk_i);
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
